[sv/mhd_pkg.sv]
// Shared constants, types and register codes of the Mahalanobis distance unit.
`default_nettype none
package mhd_pkg;

    // Fixed point format and datapath widths
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int COEF_W     = PROD_W + 1;
    localparam int DET_W      = 100;
    localparam int Q_W        = 132;
    localparam int QUO_W      = 64;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = QUO_W / 2;
    localparam int FRONT_STGS = 5;
    localparam int NSTG       = FRONT_STGS + DIV_STEPS + SQRT_STEPS;
    localparam int NTERMS     = 6;

    // Configuration registers
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COV_XY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COV_XZ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COV_YZ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_Z  = 3'd5;
    localparam logic [DATA_W-1:0]    CFG_ONE    = DATA_W'(1) << FRAC_BITS;

    // Cycles for derived matrix terms to settle after a write
    localparam int SETTLE_W = 3;
    localparam logic [SETTLE_W-1:0] SETTLE_CYC = 3'd4;

    // Determinant bound (exclusive): a determinant must exceed it to pass
    localparam logic [DET_W-1:0] DET_MIN = DET_W'(1) << (2 * FRAC_BITS);

    // Quadratic form terms that appear twice (xy, xz, yz)
    localparam logic [NTERMS-1:0] TERM_DBL = 6'b010110;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DET   = 2'd1,
        ST_XX    = 2'd2,
        ST_MINOR = 2'd3
    } t_status;

    typedef struct packed {
        logic    last;
        logic    zero;
        logic    sat;
        t_status status;
    } t_tag;

    typedef struct packed {
        logic [DATA_W-1:0] distance;
        t_status           status;
        logic              last;
    } t_result;

endpackage
`default_nettype wire

[sv/mahalanobis_distance_3d_unit.sv]
// Mahalanobis distance unit: pipelined cofactor form, long division and square root.
// Pipeline: 5 product/sum stages, 64 restoring division stages, 32 square root
// stages, output register. Throughput: one transaction per cycle while o_in_stall
// is low; a two-entry output buffer absorbs stalls. After reset and after each
// register write the input stalls while the determinant and cofactors settle.
// Reset restores the identity matrix.
`default_nettype none
module mahalanobis_distance_3d_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [mhd_pkg::DATA_W-1:0] i_offset_x,
    input  wire logic signed [mhd_pkg::DATA_W-1:0] i_offset_y,
    input  wire logic signed [mhd_pkg::DATA_W-1:0] i_offset_z,
    input  wire logic                           i_last_pair,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [mhd_pkg::DATA_W-1:0]          o_distance,
    output logic [1:0]                          o_status,
    output logic                                o_last_out,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mhd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mhd_pkg::DATA_W-1:0]     i_cfg_data
);
    import mhd_pkg::*;

    // Configuration registers and settle counter
    logic signed [DATA_W-1:0] r_c11, r_c12, r_c13, r_c22, r_c23, r_c33;
    logic [SETTLE_W-1:0]      r_settle;
    logic                     cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c11    <= CFG_ONE;
            r_c12    <= '0;
            r_c13    <= '0;
            r_c22    <= CFG_ONE;
            r_c23    <= '0;
            r_c33    <= CFG_ONE;
            r_settle <= SETTLE_CYC;
        end else begin
            if (cfg_wr) begin
                r_settle <= SETTLE_CYC;
                case (i_cfg_index)
                    REG_VAR_X:  r_c11 <= i_cfg_data;
                    REG_COV_XY: r_c12 <= i_cfg_data;
                    REG_COV_XZ: r_c13 <= i_cfg_data;
                    REG_VAR_Y:  r_c22 <= i_cfg_data;
                    REG_COV_YZ: r_c23 <= i_cfg_data;
                    REG_VAR_Z:  r_c33 <= i_cfg_data;
                    default: ;
                endcase
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 1'b1;
            end
        end
    end

    // Derived matrix terms: cofactors and leading minor
    logic signed [COEF_W-1:0] r_a11, r_a12, r_a13, r_a22, r_a23, r_minor;
    always_ff @(posedge i_clk) begin
        r_a11   <= COEF_W'(r_c22) * COEF_W'(r_c33) - COEF_W'(r_c23) * COEF_W'(r_c23);
        r_a12   <= COEF_W'(r_c13) * COEF_W'(r_c23) - COEF_W'(r_c12) * COEF_W'(r_c33);
        r_a13   <= COEF_W'(r_c12) * COEF_W'(r_c23) - COEF_W'(r_c13) * COEF_W'(r_c22);
        r_a22   <= COEF_W'(r_c11) * COEF_W'(r_c33) - COEF_W'(r_c13) * COEF_W'(r_c13);
        r_a23   <= COEF_W'(r_c12) * COEF_W'(r_c13) - COEF_W'(r_c11) * COEF_W'(r_c23);
        r_minor <= COEF_W'(r_c11) * COEF_W'(r_c22) - COEF_W'(r_c12) * COEF_W'(r_c12);
    end

    // Determinant by first row expansion, split multiplies
    logic signed [COEF_W-1:0] r_dlo [3];
    logic signed [COEF_W-1:0] r_dhi [3];
    logic signed [DET_W-1:0]  r_det;
    t_status                  r_status;
    logic signed [DATA_W-1:0] row_c [3];
    logic signed [COEF_W-1:0] row_a [3];

    assign row_c[0] = r_c11;
    assign row_c[1] = r_c12;
    assign row_c[2] = r_c13;
    assign row_a[0] = r_a11;
    assign row_a[1] = r_a12;
    assign row_a[2] = r_a13;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dlo[i] <= COEF_W'(row_c[i])
                        * COEF_W'($signed({1'b0, row_a[i][DATA_W-1:0]}));
            r_dhi[i] <= COEF_W'(row_c[i])
                        * COEF_W'($signed(row_a[i][COEF_W-1:DATA_W]));
        end
        r_det <= (DET_W'(r_dhi[0]) <<< DATA_W) + DET_W'(r_dlo[0])
               + (DET_W'(r_dhi[1]) <<< DATA_W) + DET_W'(r_dlo[1])
               + (DET_W'(r_dhi[2]) <<< DATA_W) + DET_W'(r_dlo[2]);
        if (!(r_det > $signed(DET_MIN))) begin
            r_status <= ST_DET;
        end else if (r_c11 <= 0) begin
            r_status <= ST_XX;
        end else if (r_minor <= 0) begin
            r_status <= ST_MINOR;
        end else begin
            r_status <= ST_OK;
        end
    end

    // Pipeline advance and input handshake
    logic en, in_acc, r_sv;
    assign en         = !r_sv;
    assign o_in_stall = r_sv || (r_settle != '0);
    assign in_acc     = i_in_valid && !o_in_stall;

    logic [NSTG:1] r_valid;
    t_tag          r_tag [1:NSTG];
    t_tag          n_tag5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[NSTG-1:1], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[1] <= '{last: i_last_pair, zero: 1'b0, sat: 1'b0, status: r_status};
            for (int i = 2; i <= NSTG; i++) begin
                r_tag[i] <= (i == FRONT_STGS) ? n_tag5 : r_tag[i-1];
            end
        end
    end

    // Stage 1: pairwise offset products
    logic signed [PROD_W-1:0] r_p [NTERMS];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= PROD_W'(i_offset_x) * PROD_W'(i_offset_x);
            r_p[1] <= PROD_W'(i_offset_x) * PROD_W'(i_offset_y);
            r_p[2] <= PROD_W'(i_offset_x) * PROD_W'(i_offset_z);
            r_p[3] <= PROD_W'(i_offset_y) * PROD_W'(i_offset_y);
            r_p[4] <= PROD_W'(i_offset_y) * PROD_W'(i_offset_z);
            r_p[5] <= PROD_W'(i_offset_z) * PROD_W'(i_offset_z);
        end
    end

    // Stage 2: partial products of cofactor by offset product
    logic signed [COEF_W-1:0] coef [NTERMS];
    logic [PROD_W-1:0]        r_pll [NTERMS];
    logic signed [COEF_W-1:0] r_plh [NTERMS];
    logic signed [COEF_W:0]   r_phl [NTERMS];
    logic signed [COEF_W-1:0] r_phh [NTERMS];

    assign coef[0] = r_a11;
    assign coef[1] = r_a12;
    assign coef[2] = r_a13;
    assign coef[3] = r_a22;
    assign coef[4] = r_a23;
    assign coef[5] = r_minor;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < NTERMS; t++) begin
                r_pll[t] <= PROD_W'(coef[t][DATA_W-1:0]) * PROD_W'(r_p[t][DATA_W-1:0]);
                r_plh[t] <= COEF_W'($signed({1'b0, coef[t][DATA_W-1:0]}))
                            * COEF_W'($signed(r_p[t][PROD_W-1:DATA_W]));
                r_phl[t] <= (COEF_W+1)'($signed(coef[t][COEF_W-1:DATA_W]))
                            * (COEF_W+1)'($signed({1'b0, r_p[t][DATA_W-1:0]}));
                r_phh[t] <= COEF_W'($signed(coef[t][COEF_W-1:DATA_W]))
                            * COEF_W'($signed(r_p[t][PROD_W-1:DATA_W]));
            end
        end
    end

    // Stage 3: assemble each term
    logic [Q_W-1:0] r_term [NTERMS];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < NTERMS; t++) begin
                r_term[t] <= Q_W'(r_pll[t]) + (Q_W'(r_plh[t]) << DATA_W)
                           + (Q_W'(r_phl[t]) << DATA_W) + (Q_W'(r_phh[t]) << PROD_W);
            end
        end
    end

    // Stage 4: quadratic form, cross terms doubled
    logic [Q_W-1:0] r_q;
    logic [Q_W-1:0] q_sum;
    always_comb begin
        q_sum = '0;
        for (int t = 0; t < NTERMS; t++) begin
            q_sum = q_sum + (TERM_DBL[t] ? (r_term[t] << 1) : r_term[t]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q <= q_sum;
        end
    end

    // Stage 5: sign, overflow check and division set-up
    logic [Q_W-1:0]   q_hi;
    logic [DET_W-1:0] det_u;
    logic             q_pos;
    logic [DET_W-1:0] r_drem [0:DIV_STEPS];
    logic [QUO_W-1:0] r_dnum [0:DIV_STEPS];
    logic [QUO_W-1:0] r_dquo [0:DIV_STEPS];

    assign det_u = r_det;
    assign q_hi  = r_q >> (QUO_W - FRAC_BITS);
    assign q_pos = !r_q[Q_W-1] && (r_q != '0);

    always_comb begin
        n_tag5      = r_tag[FRONT_STGS-1];
        n_tag5.zero = (r_tag[FRONT_STGS-1].status != ST_OK) || !q_pos;
        n_tag5.sat  = q_hi >= Q_W'(det_u);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drem[0] <= q_hi[DET_W-1:0];
            r_dnum[0] <= {r_q[QUO_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
            r_dquo[0] <= '0;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [DET_W-1:0] w_shift;
        logic [DET_W:0]   w_diff;
        logic             w_ge;
        assign w_shift = {r_drem[k][DET_W-2:0], r_dnum[k][QUO_W-1]};
        assign w_diff  = {1'b0, w_shift} - {1'b0, det_u};
        assign w_ge    = !w_diff[DET_W];
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_drem[k+1] <= w_ge ? w_diff[DET_W-1:0] : w_shift;
                r_dnum[k+1] <= {r_dnum[k][QUO_W-2:0], 1'b0};
                r_dquo[k+1] <= {r_dquo[k][QUO_W-2:0], w_ge};
            end
        end
    end

    // Integer square root, one result bit per stage
    logic [QUO_W-1:0] r_sx [1:SQRT_STEPS];
    logic [QUO_W-1:0] r_sr [1:SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [QUO_W-1:0] SBIT = QUO_W'(1) << (QUO_W - 2 - 2 * j);
        logic [QUO_W-1:0] w_x, w_r, w_trial;
        logic             w_ge;
        if (j == 0) begin : g_first
            assign w_x = r_dquo[DIV_STEPS];
            assign w_r = '0;
        end else begin : g_next
            assign w_x = r_sx[j];
            assign w_r = r_sr[j];
        end
        assign w_trial = w_r + SBIT;
        assign w_ge    = w_x >= w_trial;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sx[j+1] <= w_ge ? (w_x - w_trial) : w_x;
                r_sr[j+1] <= w_ge ? ((w_r >> 1) + SBIT) : (w_r >> 1);
            end
        end
    end

    // Final result selection
    t_result pipe_res;
    always_comb begin
        pipe_res.status = r_tag[NSTG].status;
        pipe_res.last   = r_tag[NSTG].last;
        if (r_tag[NSTG].zero) begin
            pipe_res.distance = '0;
        end else if (r_tag[NSTG].sat) begin
            pipe_res.distance = '1;
        end else begin
            pipe_res.distance = r_sr[SQRT_STEPS][DATA_W-1:0];
        end
    end

    // Output register with skid entry
    logic    r_ov, out_acc, incoming;
    t_result r_ores, r_sres;

    assign out_acc  = r_ov && !i_out_stall;
    assign incoming = en && r_valid[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (out_acc) begin
                r_sv <= 1'b0;
            end
        end else if (!r_ov || out_acc) begin
            r_ov <= incoming;
        end else if (incoming) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (out_acc) begin
                r_ores <= r_sres;
            end
        end else if (!r_ov || out_acc) begin
            r_ores <= pipe_res;
        end else if (incoming) begin
            r_sres <= pipe_res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_distance  = r_ores.distance;
    assign o_status    = r_ores.status;
    assign o_last_out  = r_ores.last;

endmodule
`default_nettype wire

[sv/mhd_checker.sv]
// Port-level checks of the Mahalanobis distance unit, bound to the top level.
`default_nettype none
module mhd_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [mhd_pkg::DATA_W-1:0]     o_distance,
    input wire logic [1:0]                     o_status,
    input wire logic                           o_last_out,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready
);
    import mhd_pkg::*;

    // An invalid matrix always gives a zero distance
    a_bad_matrix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_distance == '0))
        else $error("non-zero distance with invalid matrix");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_distance)
            && $stable(o_status) && $stable(o_last_out)))
        else $error("stalled result changed");

    // Block input while derived terms settle after a write
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> o_in_stall)
        else $error("input taken right after register write");

    // Drop results on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind mahalanobis_distance_3d_unit mhd_checker u_mhd_checker (.*);
`default_nettype wire

[bench/mahalanobis_distance_3d_unit_test.sv]
// Self-checking testbench of the Mahalanobis distance unit with its own exact-arithmetic predictor.
`default_nettype none
module mahalanobis_distance_3d_unit_test;
    import mhd_pkg::*;

    localparam int LIMIT_CYC = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
    localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S_MIN = 32'sh80000000;
    localparam logic signed [31:0] ONE   = 32'sh00010000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [31:0] i_offset_x = '0;
    logic signed [31:0] i_offset_y = '0;
    logic signed [31:0] i_offset_z = '0;
    logic i_last_pair = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [31:0] o_distance;
    logic [1:0] o_status;
    logic o_last_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    logic signed [31:0] cov_reg [6];
    t_result expected_results [$];
    int mismatches = 0;
    int cycles = 0;
    bit gaps_on = 1'b0;

    mahalanobis_distance_3d_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_offset_x(i_offset_x), .i_offset_y(i_offset_y), .i_offset_z(i_offset_z),
        .i_last_pair(i_last_pair),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_distance(o_distance), .o_status(o_status), .o_last_out(o_last_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Integer square root, floor
    function automatic logic [31:0] int_sqrt(input logic [63:0] val);
        logic [63:0] rem, root, bitv;
        rem = val;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[31:0];
    endfunction

    // Exact distance from the cofactor form and determinant
    function automatic t_result predict_distance(input logic signed [31:0] x, y, z,
                                                 input logic last);
        logic signed [255:0] c11, c12, c13, c22, c23, c33, vx, vy, vz;
        logic signed [255:0] det, minor, a11, a12, a13, a22, a23, q, num;
        logic [255:0] quo;
        t_result r;
        c11 = cov_reg[REG_VAR_X];  c12 = cov_reg[REG_COV_XY];
        c13 = cov_reg[REG_COV_XZ]; c22 = cov_reg[REG_VAR_Y];
        c23 = cov_reg[REG_COV_YZ]; c33 = cov_reg[REG_VAR_Z];
        vx = x; vy = y; vz = z;
        det = c11 * c22 * c33 - c12 * c12 * c33 - c11 * c23 * c23
            + 2 * c12 * c13 * c23 - c13 * c13 * c22;
        minor = c11 * c22 - c12 * c12;
        r.distance = '0;
        r.last = last;
        if (det <= (256'sd1 <<< (2 * FRAC_BITS))) r.status = ST_DET;
        else if (c11 <= 0) r.status = ST_XX;
        else if (minor <= 0) r.status = ST_MINOR;
        else r.status = ST_OK;
        if (r.status == ST_OK) begin
            a11 = c22 * c33 - c23 * c23;
            a12 = c13 * c23 - c12 * c33;
            a13 = c12 * c23 - c13 * c22;
            a22 = c11 * c33 - c13 * c13;
            a23 = c12 * c13 - c11 * c23;
            q = a11 * vx * vx + 2 * a12 * vx * vy + 2 * a13 * vx * vz
              + a22 * vy * vy + 2 * a23 * vy * vz + minor * vz * vz;
            if (q > 0) begin
                num = q <<< FRAC_BITS;
                if (num >= (det <<< 64)) begin
                    r.distance = 32'hFFFFFFFF;
                end else begin
                    quo = $unsigned(num) / $unsigned(det);
                    r.distance = int_sqrt(quo[63:0]);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got, want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // Send one offset transaction, with random idle cycles ahead of it when enabled
    task automatic send_offset(input logic signed [31:0] x, y, z, input logic last);
        while (gaps_on && $urandom_range(0, 99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_offset_x <= x;
        i_offset_y <= y;
        i_offset_z <= z;
        i_last_pair <= last;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_distance(x, y, z, last));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Write one register; only called while the unit is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic signed [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx <= REG_VAR_Z) cov_reg[idx] = val;
    endtask

    task automatic load_matrix(input logic signed [31:0] xx, xy, xz, yy, yz, zz);
        drain_results();
        write_reg(REG_VAR_X, xx);
        write_reg(REG_COV_XY, xy);
        write_reg(REG_COV_XZ, xz);
        write_reg(REG_VAR_Y, yy);
        write_reg(REG_COV_YZ, yz);
        write_reg(REG_VAR_Z, zz);
    endtask

    function automatic logic signed [31:0] rand_offset();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh0001FFFF;
            2: return $signed($urandom_range(0, 32'h03FFFFFF)) - 32'sh01FFFFFF;
            default: return $urandom_range(0, 1) ? S_MAX - $urandom_range(0, 255)
                                                 : S_MIN + $urandom_range(0, 255);
        endcase
    endfunction

    // Identity after reset, including offset extremes
    task automatic test_reset_identity();
        send_offset(0, 0, 0, 1'b0);
        send_offset(ONE, 0, 0, 1'b0);
        send_offset(S_MAX, S_MAX, S_MAX, 1'b1);
        send_offset(S_MIN, S_MIN, S_MIN, 1'b0);
        send_offset(S_MIN, S_MAX, -ONE, 1'b1);
        send_offset(32'sh5555AAAA, 32'shAAAA5555, 1, 1'b0);
    endtask

    // Each status code, unknown indexes and saturation
    task automatic test_status_and_saturation();
        load_matrix(0, 0, 0, 0, 0, 0);
        send_offset(ONE, ONE, ONE, 1'b1);
        load_matrix(-ONE, 0, 0, -ONE, 0, ONE);
        send_offset(ONE, 0, 0, 1'b0);
        load_matrix(ONE, 0, 0, -ONE, 0, -ONE);
        send_offset(ONE, ONE, 0, 1'b1);
        load_matrix(32'sd2048, 0, 0, 32'sd2048, 0, 32'sd2048);
        send_offset(S_MAX, 0, 0, 1'b0);
        send_offset(1, 1, 1, 1'b1);
        send_offset(0, 0, 0, 1'b0);
        load_matrix(S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX);
        send_offset(S_MAX, S_MIN, S_MAX, 1'b0);
        load_matrix(S_MAX, 0, 0, S_MAX, 0, S_MAX);
        send_offset(S_MIN, S_MIN, S_MIN, 1'b1);
        send_offset(1, -1, 1, 1'b0);
        drain_results();
        write_reg(REG_UNUSED_LO, 32'shFFFFFFFF);
        write_reg(REG_UNUSED_HI, 0);
        send_offset(ONE, ONE, ONE, 1'b1);
    endtask

    // Random matrices, mostly well conditioned, some arbitrary
    task automatic test_random();
        logic signed [31:0] xx, yy, zz, xy, xz, yz;
        for (int phase = 0; phase < 18; phase++) begin
            if (phase % 6 == 5) begin
                xx = $urandom(); yy = $urandom(); zz = $urandom();
                xy = $urandom(); xz = $urandom(); yz = $urandom();
            end else begin
                xx = $urandom_range(32'h100, 32'h7FFFFFFF);
                yy = $urandom_range(32'h100, 32'h7FFFFFFF);
                zz = $urandom_range(32'h100, 32'h7FFFFFFF);
                xy = $signed($urandom_range(0, 32'h1FFFFFFF)) - 32'sh0FFFFFFF;
                xz = $signed($urandom_range(0, 32'h1FFFFFFF)) - 32'sh0FFFFFFF;
                yz = $signed($urandom_range(0, 32'h1FFFFFFF)) - 32'sh0FFFFFFF;
            end
            load_matrix(xx, xy, xz, yy, yz, zz);
            gaps_on = (phase >= 3);
            repeat (30) send_offset(rand_offset(), rand_offset(), rand_offset(),
                                    1'($urandom_range(0, 1)));
        end
        gaps_on = 1'b0;
    endtask

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_distance, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_distance !== want.distance)
                    report_mismatch("distance", o_distance, want.distance);
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_last_out !== want.last)
                    report_mismatch("last", 32'(o_last_out), 32'(want.last));
            end
        end
        i_out_stall <= gaps_on && ($urandom_range(0, 99) < 37);
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC) begin
            $display("mahalanobis_distance_3d_unit_test: FAIL");
            $finish;
        end
    end

    initial begin
        cov_reg[REG_VAR_X] = ONE;  cov_reg[REG_COV_XY] = 0; cov_reg[REG_COV_XZ] = 0;
        cov_reg[REG_VAR_Y] = ONE;  cov_reg[REG_COV_YZ] = 0; cov_reg[REG_VAR_Z] = ONE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_identity();
        test_status_and_saturation();
        test_random();
        drain_results();
        repeat (120) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("mahalanobis_distance_3d_unit_test: PASS");
        end else begin
            $display("mahalanobis_distance_3d_unit_test: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
